FILE: src/skbc_pkg.sv
package skbc_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int COEFF_BITS  = 24;

   // shared multiplier: 33 bits covers (2^COEFF_BITS - c) at COEFF_BITS = 32
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = COEFF_BITS + 33;

   // knee divide: numerator, denominator and dividend widths
   localparam int NUM_W = 43;
   localparam int DEN_W = 30;
   localparam int DVD_W = NUM_W + 1;

   localparam int CNT_W      = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_MAKEUP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RATIO     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KNEE_PT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KNEE_W    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET    = 3'd6;

   localparam logic [12:0] UNITY_RATIO     = 13'd256;
   localparam logic [13:0] MIN_KNEE_W      = 14'd26;
   localparam logic [31:0] DB_PER_LOG2_Q16 = 32'd394566;
   localparam logic [31:0] LOG2_PER_DB_Q24 = 32'd2786635;

   localparam logic [COEFF_BITS-1:0] ATTACK_RESET  = COEFF_BITS'(24'd16742300);
   localparam logic [COEFF_BITS-1:0] RELEASE_RESET = COEFF_BITS'(24'd16773721);

   // 2^x Taylor terms, Q1.30
   function automatic logic [31:0] exp_poly(input logic [2:0] k);
      logic [31:0] v;
      case (k)
         3'd0: v = 32'd1073741824;
         3'd1: v = 32'd744261118;
         3'd2: v = 32'd257941248;
         3'd3: v = 32'd59597083;
         3'd4: v = 32'd10327387;
         3'd5: v = 32'd1431680;
         3'd6: v = 32'd165394;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_ENV1, OP_ENV2, OP_ENV3, OP_NORM, OP_SQR, OP_DB1, OP_DB2,
      OP_CURVE, OP_K1, OP_K2, OP_K3, OP_K4, OP_DIV, OP_G1, OP_G2, OP_H1, OP_H2,
      OP_P1, OP_OUT
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ENV1, ST_ENV2, ST_ENV3, ST_NORM, ST_SQR, ST_DB1, ST_DB2, ST_CURVE,
      ST_K1, ST_K2, ST_K3, ST_K4, ST_DIV, ST_G1, ST_G2, ST_H1, ST_H2, ST_P1, ST_P2
   } state_type;

   typedef struct packed {
      op_type           op;
      logic [CNT_W-1:0] cnt;
   } cmd_type;

   typedef struct packed {
      logic curve_zero;
      logic out_busy;
   } status_type;

endpackage

FILE: src/soft_knee_band_compressor.sv
// A req beat is taken only once the last one has reached the output register.
//   Each runs the 44-step knee divider, plus the 16 log squarings and the 7-term
//   exp polynomial on one shared multiplier; the knee steps are skipped when the
//   curve is bypassed (ratio at or below unity) or the level is at/below the knee.
// Reset (synchronous, active high): envelope cleared, registers to defaults,
//   no result pending.
module soft_knee_band_compressor (
   input  logic                                    clock,
   input  logic                                    reset,
   // sample in
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [skbc_pkg::SAMPLE_BITS-1:0] req_sample_in,
   // result out
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [skbc_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output logic signed [15:0]                      rsp_gain_reduction_db,
   output logic signed [15:0]                      rsp_envelope_level_db,
   // register writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [skbc_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [skbc_pkg::CSR_DATA_W-1:0]         csr_data
);

   // The controller walks one sample through envelope, log2, dB, knee
   // curve, exp2 and scaling; the datapath holds the shared multiplier,
   // the leading-one search, the divider and the output register.
   // A finished result waits in the output register while the next
   // sample is already being accepted and worked on.

   skbc_pkg::cmd_type    cmd;
   skbc_pkg::status_type status;

   // register writes are taken every cycle
   assign csr_ready = 1'b1;

   skbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   skbc_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_sample_in         (req_sample_in),
      .csr_valid             (csr_valid),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .rsp_ready             (rsp_ready),
      .rsp_valid             (rsp_valid),
      .rsp_sample_out        (rsp_sample_out),
      .rsp_gain_reduction_db (rsp_gain_reduction_db),
      .rsp_envelope_level_db (rsp_envelope_level_db)
   );

endmodule

FILE: src/skbc_ctrl.sv
module skbc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  skbc_pkg::status_type status,
   output skbc_pkg::cmd_type    cmd
);

   localparam logic [skbc_pkg::CNT_W-1:0] NORM_LAST = skbc_pkg::CNT_W'(4);
   localparam logic [skbc_pkg::CNT_W-1:0] SQR_LAST  = skbc_pkg::CNT_W'(15);
   localparam logic [skbc_pkg::CNT_W-1:0] DIV_LAST  = skbc_pkg::CNT_W'(skbc_pkg::DVD_W - 1);
   localparam logic [skbc_pkg::CNT_W-1:0] POLY_TOP  = skbc_pkg::CNT_W'(5);

   skbc_pkg::state_type           state_ff, state_in;
   logic [skbc_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skbc_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd.op    = skbc_pkg::OP_NONE;
      cmd.cnt   = cnt_ff;
      case (state_ff)
         skbc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = skbc_pkg::OP_LOAD;
               state_in = skbc_pkg::ST_ENV1;
            end
         end
         skbc_pkg::ST_ENV1: begin
            cmd.op   = skbc_pkg::OP_ENV1;
            state_in = skbc_pkg::ST_ENV2;
         end
         skbc_pkg::ST_ENV2: begin
            cmd.op   = skbc_pkg::OP_ENV2;
            state_in = skbc_pkg::ST_ENV3;
         end
         skbc_pkg::ST_ENV3: begin
            cmd.op   = skbc_pkg::OP_ENV3;
            cnt_in   = '0;
            state_in = skbc_pkg::ST_NORM;
         end
         skbc_pkg::ST_NORM: begin
            cmd.op = skbc_pkg::OP_NORM;
            if (cnt_ff == NORM_LAST) begin
               cnt_in   = '0;
               state_in = skbc_pkg::ST_SQR;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         skbc_pkg::ST_SQR: begin
            cmd.op = skbc_pkg::OP_SQR;
            if (cnt_ff == SQR_LAST) begin
               state_in = skbc_pkg::ST_DB1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         skbc_pkg::ST_DB1: begin
            cmd.op   = skbc_pkg::OP_DB1;
            state_in = skbc_pkg::ST_DB2;
         end
         skbc_pkg::ST_DB2: begin
            cmd.op   = skbc_pkg::OP_DB2;
            state_in = skbc_pkg::ST_CURVE;
         end
         skbc_pkg::ST_CURVE: begin
            cmd.op   = skbc_pkg::OP_CURVE;
            state_in = status.curve_zero ? skbc_pkg::ST_G1 : skbc_pkg::ST_K1;
         end
         skbc_pkg::ST_K1: begin
            cmd.op   = skbc_pkg::OP_K1;
            state_in = skbc_pkg::ST_K2;
         end
         skbc_pkg::ST_K2: begin
            cmd.op   = skbc_pkg::OP_K2;
            state_in = skbc_pkg::ST_K3;
         end
         skbc_pkg::ST_K3: begin
            cmd.op   = skbc_pkg::OP_K3;
            state_in = skbc_pkg::ST_K4;
         end
         skbc_pkg::ST_K4: begin
            cmd.op   = skbc_pkg::OP_K4;
            cnt_in   = '0;
            state_in = skbc_pkg::ST_DIV;
         end
         skbc_pkg::ST_DIV: begin
            cmd.op = skbc_pkg::OP_DIV;
            if (cnt_ff == DIV_LAST) begin
               state_in = skbc_pkg::ST_G1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         skbc_pkg::ST_G1: begin
            cmd.op   = skbc_pkg::OP_G1;
            state_in = skbc_pkg::ST_G2;
         end
         skbc_pkg::ST_G2: begin
            cmd.op   = skbc_pkg::OP_G2;
            cnt_in   = POLY_TOP;
            state_in = skbc_pkg::ST_H1;
         end
         skbc_pkg::ST_H1: begin
            cmd.op   = skbc_pkg::OP_H1;
            state_in = skbc_pkg::ST_H2;
         end
         skbc_pkg::ST_H2: begin
            cmd.op = skbc_pkg::OP_H2;
            if (cnt_ff == '0) begin
               state_in = skbc_pkg::ST_P1;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = skbc_pkg::ST_H1;
            end
         end
         skbc_pkg::ST_P1: begin
            cmd.op   = skbc_pkg::OP_P1;
            state_in = skbc_pkg::ST_P2;
         end
         skbc_pkg::ST_P2: begin
            if (!status.out_busy) begin
               cmd.op   = skbc_pkg::OP_OUT;
               state_in = skbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skbc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/skbc_dp.sv
module skbc_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  skbc_pkg::cmd_type                      cmd,
   output skbc_pkg::status_type                   status,
   input  logic signed [skbc_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  logic                                   csr_valid,
   input  logic [skbc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [skbc_pkg::CSR_DATA_W-1:0]        csr_data,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic signed [skbc_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output logic signed [15:0]                     rsp_gain_reduction_db,
   output logic signed [15:0]                     rsp_envelope_level_db
);

   localparam int S  = skbc_pkg::SAMPLE_BITS;
   localparam int CB = skbc_pkg::COEFF_BITS;
   localparam int MW = skbc_pkg::MUL_W;
   localparam int PW = skbc_pkg::PROD_W;
   localparam int AW = skbc_pkg::ACC_W;
   localparam int NW = skbc_pkg::NUM_W;
   localparam int DW = skbc_pkg::DEN_W;
   localparam int VW = skbc_pkg::DVD_W;

   localparam logic [AW-1:0] HALF    = AW'(1) << (CB - 1);
   localparam logic [CB:0]   ONE     = (CB + 1)'(1) << CB;
   localparam logic [63:0]   NEG_LIM = 64'(1) << (S - 1);
   localparam logic [63:0]   POS_LIM = NEG_LIM - 64'd1;

   // configuration
   logic [15:0]   makeup_ff, makeup_in;
   logic [12:0]   ratio_ff, ratio_in;
   logic [14:0]   kpt_ff, kpt_in;
   logic [13:0]   kw_ff, kw_in;
   logic [CB-1:0] att_ff, att_in;
   logic [CB-1:0] rel_ff, rel_in;
   logic [15:0]   offset_ff, offset_in;

   // working registers
   logic [31:0]   env_ff, env_in;
   logic [S-1:0]  mag_ff, mag_in;
   logic          neg_ff, neg_in;
   logic [31:0]   a_ff, a_in;
   logic [CB-1:0] coef_ff, coef_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [31:0]   n_ff, n_in;
   logic [4:0]    p_ff, p_in;
   logic [15:0]   frac_ff, frac_in;
   logic          sgn_ff, sgn_in;
   logic [15:0]   level_ff, level_in;
   logic          knee_ff, knee_in;
   logic [16:0]   opnd_ff, opnd_in;
   logic [13:0]   weff_ff, weff_in;
   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvd_ff, dvd_in;
   logic [8:0]    ip_ff, ip_in;
   logic [29:0]   x_ff, x_in;
   logic [31:0]   hacc_ff, hacc_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [S-1:0]  out_s_ff, out_s_in;
   logic [15:0]   out_gr_ff, out_gr_in;
   logic [15:0]   out_lv_ff, out_lv_in;

   // combinational helpers
   logic [MW-1:0] mul_a, mul_b;
   logic [PW-1:0] mul_p;
   logic [CB:0]   one_minus_c;
   logic [AW-1:0] env_sum;
   logic [5:0]    sh;
   logic [32:0]   sq;
   logic [21:0]   l2, l2m;
   logic [47:0]   db_sum;
   logic [19:0]   db_mag;
   logic [20:0]   db;
   logic [21:0]   lvl_raw;
   logic [19:0]   x20, x2, t2, wv, lo, hi, d2, xt;
   logic          is_knee;
   logic [DW:0]   r2;
   logic          ge;
   logic [17:0]   desired, dmag;
   logic [39:0]   e_sum;
   logic [23:0]   e_mag;
   logic [24:0]   e_val;
   logic [9:0]    rsh;
   logic [63:0]   om;
   logic [S-1:0]  om_sat;

   assign mul_p = mul_a * mul_b;
   assign one_minus_c = ONE - {1'b0, coef_ff};

   // knee geometry, evaluated on the registered level
   always_comb begin
      weff_in = (kw_ff < skbc_pkg::MIN_KNEE_W) ? skbc_pkg::MIN_KNEE_W : kw_ff;
      x20     = {{4{level_ff[15]}}, level_ff};
      x2      = {{3{level_ff[15]}}, level_ff, 1'b0};
      t2      = {4'b0, kpt_ff, 1'b0};
      wv      = {6'b0, weff_in};
      lo      = t2 - wv;
      hi      = t2 + wv;
      d2      = x2 - lo;
      xt      = x20 - {5'b0, kpt_ff};
      is_knee = $signed(x2) < $signed(hi);
      status.curve_zero = (ratio_ff <= skbc_pkg::UNITY_RATIO) || ($signed(x2) <= $signed(lo));
      status.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      makeup_in = makeup_ff;
      ratio_in  = ratio_ff;
      kpt_in    = kpt_ff;
      kw_in     = kw_ff;
      att_in    = att_ff;
      rel_in    = rel_ff;
      offset_in = offset_ff;
      if (csr_valid) begin
         case (csr_index)
            skbc_pkg::REG_MAKEUP:  makeup_in = csr_data[15:0];
            skbc_pkg::REG_RATIO:   ratio_in  = csr_data[12:0];
            skbc_pkg::REG_KNEE_PT: kpt_in    = csr_data[14:0];
            skbc_pkg::REG_KNEE_W:  kw_in     = csr_data[13:0];
            skbc_pkg::REG_ATTACK:  att_in    = csr_data[CB-1:0];
            skbc_pkg::REG_RELEASE: rel_in    = csr_data[CB-1:0];
            skbc_pkg::REG_OFFSET:  offset_in = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      env_in   = env_ff;   mag_in  = mag_ff;   neg_in  = neg_ff;   a_in    = a_ff;
      coef_in  = coef_ff;  acc_in  = acc_ff;   prod_in = prod_ff;  n_in    = n_ff;
      p_in     = p_ff;     frac_in = frac_ff;  sgn_in  = sgn_ff;   level_in = level_ff;
      knee_in  = knee_ff;  opnd_in = opnd_ff;  num_in  = num_ff;   den_in  = den_ff;
      rem_in   = rem_ff;   dvd_in  = dvd_ff;   ip_in   = ip_ff;    x_in    = x_ff;
      hacc_in  = hacc_ff;
      out_s_in = out_s_ff; out_gr_in = out_gr_ff; out_lv_in = out_lv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_a = '0;
      mul_b = '0;
      env_sum = '0; sh = '0; sq = '0; l2 = '0; l2m = '0; db_sum = '0; db_mag = '0;
      db = '0; lvl_raw = '0; r2 = '0; ge = 1'b0; desired = '0; dmag = '0;
      e_sum = '0; e_mag = '0; e_val = '0; rsh = '0; om = '0; om_sat = '0;
      case (cmd.op)
         skbc_pkg::OP_LOAD: begin
            neg_in  = req_sample_in[S-1];
            mag_in  = neg_in ? S'(-req_sample_in) : S'(req_sample_in);
            a_in    = 32'(mag_in) << (32 - S);
            coef_in = (a_in > env_ff) ? att_ff : rel_ff;
         end
         skbc_pkg::OP_ENV1: begin
            mul_a   = MW'(coef_ff);
            mul_b   = MW'(env_ff);
            prod_in = mul_p;
         end
         skbc_pkg::OP_ENV2: begin
            acc_in  = AW'(prod_ff);
            mul_a   = MW'(one_minus_c);
            mul_b   = MW'(a_ff);
            prod_in = mul_p;
         end
         skbc_pkg::OP_ENV3: begin
            env_sum = acc_ff + AW'(prod_ff) + HALF;
            env_in  = 32'(env_sum >> CB);
            n_in    = (env_in == 32'd0) ? 32'd1 : env_in;
            p_in    = 5'd31;
            frac_in = '0;
         end
         skbc_pkg::OP_NORM: begin
            // leading-one search, 16/8/4/2/1 place steps
            sh = 6'd16 >> cmd.cnt;
            if ((n_ff >> (6'd32 - sh)) == 32'd0) begin
               n_in = n_ff << sh;
               p_in = p_ff - sh[4:0];
            end
         end
         skbc_pkg::OP_SQR: begin
            mul_a = MW'(n_ff);
            mul_b = MW'(n_ff);
            sq    = mul_p[63:31];
            if (sq[32]) begin
               frac_in = {frac_ff[14:0], 1'b1};
               n_in    = sq[32:1];
            end else begin
               frac_in = {frac_ff[14:0], 1'b0};
               n_in    = sq[31:0];
            end
         end
         skbc_pkg::OP_DB1: begin
            l2      = {({1'b0, p_ff} - 6'd31), frac_ff};
            sgn_in  = l2[21];
            l2m     = l2[21] ? -l2 : l2;
            mul_a   = MW'(l2m);
            mul_b   = MW'(skbc_pkg::DB_PER_LOG2_Q16);
            prod_in = mul_p;
         end
         skbc_pkg::OP_DB2: begin
            // floor shift of a signed product
            db_sum  = sgn_ff ? (prod_ff[47:0] + 48'hFF_FFFF) : prod_ff[47:0];
            db_mag  = db_sum[43:24];
            db      = sgn_ff ? -{1'b0, db_mag} : {1'b0, db_mag};
            lvl_raw = {db[20], db} + {{6{offset_ff[15]}}, offset_ff};
            if ($signed(lvl_raw) > $signed(22'sd32767)) begin
               level_in = 16'h7FFF;
            end else if ($signed(lvl_raw) < $signed(-22'sd32768)) begin
               level_in = 16'h8000;
            end else begin
               level_in = lvl_raw[15:0];
            end
         end
         skbc_pkg::OP_CURVE: begin
            knee_in = is_knee;
            opnd_in = is_knee ? d2[16:0] : xt[16:0];
            dvd_in  = '0;
         end
         skbc_pkg::OP_K1: begin
            mul_a   = MW'(opnd_ff);
            mul_b   = knee_ff ? MW'(opnd_ff) : MW'(1);
            prod_in = mul_p;
         end
         skbc_pkg::OP_K2: begin
            mul_a   = MW'(prod_ff[31:0]);
            mul_b   = MW'(ratio_ff - skbc_pkg::UNITY_RATIO);
            prod_in = mul_p;
         end
         skbc_pkg::OP_K3: begin
            num_in  = prod_ff[NW-1:0];
            mul_a   = knee_ff ? MW'(weff_ff) : MW'(1);
            mul_b   = MW'(ratio_ff);
            prod_in = mul_p;
         end
         skbc_pkg::OP_K4: begin
            den_in = knee_ff ? {prod_ff[DW-4:0], 3'b000} : prod_ff[DW-1:0];
            dvd_in = VW'(num_ff) + VW'(den_in >> 1);
            rem_in = '0;
         end
         skbc_pkg::OP_DIV: begin
            // restoring divide, one quotient bit a cycle
            r2     = {rem_ff, dvd_ff[VW-1]};
            ge     = r2 >= {1'b0, den_ff};
            rem_in = ge ? DW'(r2 - {1'b0, den_ff}) : r2[DW-1:0];
            dvd_in = {dvd_ff[VW-2:0], ge};
         end
         skbc_pkg::OP_G1: begin
            desired = {{2{makeup_ff[15]}}, makeup_ff} - {2'b00, dvd_ff[15:0]};
            sgn_in  = desired[17];
            dmag    = desired[17] ? -desired : desired;
            mul_a   = MW'(dmag);
            mul_b   = MW'(skbc_pkg::LOG2_PER_DB_Q24);
            prod_in = mul_p;
         end
         skbc_pkg::OP_G2: begin
            e_sum   = sgn_ff ? (prod_ff[39:0] + 40'hFFFF) : prod_ff[39:0];
            e_mag   = e_sum[39:16];
            e_val   = sgn_ff ? -{1'b0, e_mag} : {1'b0, e_mag};
            ip_in   = e_val[24:16];
            x_in    = {e_val[15:0], 14'b0};
            hacc_in = skbc_pkg::exp_poly(3'd6);
         end
         skbc_pkg::OP_H1: begin
            mul_a   = MW'(hacc_ff);
            mul_b   = MW'(x_ff);
            prod_in = mul_p;
         end
         skbc_pkg::OP_H2: begin
            hacc_in = skbc_pkg::exp_poly(cmd.cnt[2:0]) + prod_ff[61:30];
         end
         skbc_pkg::OP_P1: begin
            mul_a   = MW'(mag_ff);
            mul_b   = MW'(hacc_ff);
            prod_in = mul_p;
         end
         skbc_pkg::OP_OUT: begin
            rsh = 10'sd30 - {ip_ff[8], ip_ff};
            if (rsh[9] || rsh == 10'd0) begin
               om = (prod_ff[63:0] != 64'd0) ? NEG_LIM : 64'd0;
            end else if (rsh >= 10'd64) begin
               om = 64'd0;
            end else begin
               om = prod_ff[63:0] >> rsh[5:0];
            end
            if (neg_ff) begin
               om_sat   = (om > NEG_LIM) ? NEG_LIM[S-1:0] : om[S-1:0];
               out_s_in = -om_sat;
            end else begin
               om_sat   = (om > POS_LIM) ? POS_LIM[S-1:0] : om[S-1:0];
               out_s_in = om_sat;
            end
            // quotient stays below 2^15, so no clamp needed here
            out_gr_in    = dvd_ff[15:0];
            out_lv_in    = level_ff;
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         makeup_ff    <= '0;
         ratio_ff     <= skbc_pkg::UNITY_RATIO;
         kpt_ff       <= '0;
         kw_ff        <= skbc_pkg::MIN_KNEE_W;
         att_ff       <= skbc_pkg::ATTACK_RESET;
         rel_ff       <= skbc_pkg::RELEASE_RESET;
         offset_ff    <= '0;
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         makeup_ff    <= makeup_in;
         ratio_ff     <= ratio_in;
         kpt_ff       <= kpt_in;
         kw_ff        <= kw_in;
         att_ff       <= att_in;
         rel_ff       <= rel_in;
         offset_ff    <= offset_in;
         env_ff       <= env_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      a_ff      <= a_in;
      coef_ff   <= coef_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      n_ff      <= n_in;
      p_ff      <= p_in;
      frac_ff   <= frac_in;
      sgn_ff    <= sgn_in;
      level_ff  <= level_in;
      knee_ff   <= knee_in;
      opnd_ff   <= opnd_in;
      weff_ff   <= weff_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      ip_ff     <= ip_in;
      x_ff      <= x_in;
      hacc_ff   <= hacc_in;
      out_s_ff  <= out_s_in;
      out_gr_ff <= out_gr_in;
      out_lv_ff <= out_lv_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_sample_out        = out_s_ff;
   assign rsp_gain_reduction_db = out_gr_ff;
   assign rsp_envelope_level_db = out_lv_ff;

   a_norm_done: assert property (@(posedge clock) disable iff (reset)
      cmd.op == skbc_pkg::OP_DB1 |-> n_ff[31])
      else $error("log mantissa not normalized");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.op == skbc_pkg::OP_DIV |-> rem_ff < den_ff)
      else $error("divider remainder out of range");

   a_quot_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.op == skbc_pkg::OP_G1 |-> dvd_ff[VW-1:15] == '0)
      else $error("gain change exceeds 15 bits");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.op == skbc_pkg::OP_OUT |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result register overwritten while held");

endmodule

FILE: tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;   // idle cycles with no beat on any channel
   localparam int PHASES         = 9;
   localparam int ITEMS_PER_PHASE = 104;
   localparam logic [skbc_pkg::CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   typedef struct {
      logic signed [skbc_pkg::SAMPLE_BITS-1:0] smp;
      logic signed [15:0]                      gr;
      logic signed [15:0]                      lvl;
   } comp_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                    req_valid = 1'b0;
   logic                                    req_ready;
   logic signed [skbc_pkg::SAMPLE_BITS-1:0] req_sample_in = '0;
   logic                                    rsp_valid;
   logic                                    rsp_ready = 1'b0;
   logic signed [skbc_pkg::SAMPLE_BITS-1:0] rsp_sample_out;
   logic signed [15:0]                      rsp_gain_reduction_db;
   logic signed [15:0]                      rsp_envelope_level_db;
   logic                                    csr_valid = 1'b0;
   logic                                    csr_ready;
   logic [skbc_pkg::CSR_IDX_W-1:0]          csr_index = '0;
   logic [skbc_pkg::CSR_DATA_W-1:0]         csr_data = '0;

   always #1 clock = ~clock;

   soft_knee_band_compressor dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_sample_in         (req_sample_in),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_sample_out        (rsp_sample_out),
      .rsp_gain_reduction_db (rsp_gain_reduction_db),
      .rsp_envelope_level_db (rsp_envelope_level_db),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   // ------------------------------------------------------------------
   // Compressor shadow: register copies plus envelope state
   // ------------------------------------------------------------------
   logic [31:0] env_state;
   longint      gain_makeup, gain_ratio, knee_pt, knee_w, coef_attack, coef_release, spl_ofs;

   comp_result_type                         result_q[$];   // predicted results in flight
   logic signed [skbc_pkg::SAMPLE_BITS-1:0] sample_q[$];   // samples not yet driven
   int err_count = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   function automatic void shadow_reset();
      env_state    = '0;
      gain_makeup  = 0;
      gain_ratio   = 256;
      knee_pt      = 0;
      knee_w       = 26;
      coef_attack  = skbc_pkg::ATTACK_RESET;
      coef_release = skbc_pkg::RELEASE_RESET;
      spl_ofs      = 0;
   endfunction

   function automatic void shadow_write(input logic [skbc_pkg::CSR_IDX_W-1:0] idx,
                                        input logic [skbc_pkg::CSR_DATA_W-1:0] d);
      case (idx)
         skbc_pkg::REG_MAKEUP:  gain_makeup  = longint'(signed'(d[15:0]));
         skbc_pkg::REG_RATIO:   gain_ratio   = longint'(d[12:0]);
         skbc_pkg::REG_KNEE_PT: knee_pt      = longint'(d[14:0]);
         skbc_pkg::REG_KNEE_W:  knee_w       = longint'(d[13:0]);
         skbc_pkg::REG_ATTACK:  coef_attack  = longint'(d[skbc_pkg::COEFF_BITS-1:0]);
         skbc_pkg::REG_RELEASE: coef_release = longint'(d[skbc_pkg::COEFF_BITS-1:0]);
         skbc_pkg::REG_OFFSET:  spl_ofs      = longint'(signed'(d[15:0]));
         default: ;   // out-of-range index is dropped
      endcase
   endfunction

   function automatic longint clamp16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // 20*log10 of the envelope, Q8.8; log2 fraction by repeated squaring
   function automatic longint envelope_db(input logic [31:0] e);
      int          p;
      logic [63:0] n;
      longint      frac, l2;
      frac = 0;
      if (e == 0) e = 32'd1;     // silent envelope counts as one LSB
      p = 31;
      while (e[p] == 1'b0) p--;
      n = 64'(e) << (31 - p);
      for (int i = 0; i < 16; i++) begin
         n = (n * n) >> 31;
         frac = frac << 1;
         if (n >= 64'h1_0000_0000) begin
            frac = frac | 1;
            n = n >> 1;
         end
      end
      l2 = longint'(p - 31) * 65536 + frac;
      return (l2 * 394566) >>> 24;
   endfunction

   function automatic longint unsigned exp2_q30(input longint unsigned f16);
      longint unsigned xv, acc;
      longint unsigned terms [7] = '{64'd1073741824, 64'd744261118, 64'd257941248,
                                     64'd59597083, 64'd10327387, 64'd1431680, 64'd165394};
      xv  = f16 << 14;
      acc = terms[6];
      for (int k = 5; k >= 0; k--) acc = terms[k] + ((acc * xv) >> 30);
      return acc;
   endfunction

   function automatic longint knee_gain_change(input longint lv);
      longint          w;
      longint unsigned num, den, d2;
      w = (knee_w < 26) ? 26 : knee_w;    // narrow knee floor
      if (gain_ratio <= 256) return 0;     // unity ratio bypass
      if (2 * lv <= 2 * knee_pt - w) return 0;
      if (2 * lv < 2 * knee_pt + w) begin
         d2  = longint'(2 * lv - 2 * knee_pt + w);
         num = d2 * d2 * longint'(gain_ratio - 256);
         den = 8 * w * gain_ratio;
      end else begin
         num = longint'(lv - knee_pt) * longint'(gain_ratio - 256);
         den = gain_ratio;
      end
      return -longint'((num + den / 2) / den);
   endfunction

   function automatic comp_result_type compress_sample(
      input logic signed [skbc_pkg::SAMPLE_BITS-1:0] x);
      comp_result_type r;
      longint          s, lv, chg, des, e, ip, f, rsh, val;
      longint unsigned mag, a, c, acc, prod, om;
      longint unsigned pos_lim, neg_lim;
      pos_lim = (64'd1 << (skbc_pkg::SAMPLE_BITS - 1)) - 1;
      neg_lim = 64'd1 << (skbc_pkg::SAMPLE_BITS - 1);
      s   = longint'(x);
      mag = (s < 0) ? longint'(-s) : longint'(s);
      a   = mag << (32 - skbc_pkg::SAMPLE_BITS);
      // attack on a rising magnitude, release otherwise
      c   = (a > longint'(env_state)) ? coef_attack : coef_release;
      acc = c * longint'(env_state) + ((64'd1 << skbc_pkg::COEFF_BITS) - c) * a
            + (64'd1 << (skbc_pkg::COEFF_BITS - 1));
      env_state = 32'(acc >> skbc_pkg::COEFF_BITS);

      lv  = clamp16(envelope_db(env_state) + spl_ofs);
      chg = knee_gain_change(lv);
      des = gain_makeup + chg;

      e    = (des * 2786635) >>> 16;
      ip   = e >>> 16;
      f    = e - ip * 65536;
      prod = mag * exp2_q30(longint'(f));
      rsh  = 30 - ip;
      if (rsh <= 0)       om = (prod != 0) ? neg_lim : 0;
      else if (rsh >= 64) om = 0;                    // vanishing gain
      else                om = prod >> rsh;

      if (s < 0) begin
         if (om > neg_lim) om = neg_lim;
         val = -longint'(om);
      end else begin
         if (om > pos_lim) om = pos_lim;
         val = longint'(om);
      end
      r.smp = skbc_pkg::SAMPLE_BITS'(val);
      r.gr  = 16'(clamp16(-chg));
      r.lvl = 16'(lv);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Sample driver: bursts of beats separated by random gaps
   // ------------------------------------------------------------------
   bit req_taken = 1'b0;
   int burst_left = 0, gap_left = 0;
   int gap_max = 4, burst_max = 20;    // retuned per phase
   int stall_pct = 30;                 // receiver stall odds, per phase

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (sample_q.size() != 0) begin
            req_sample_in <= sample_q.pop_front();
            req_valid     <= 1'b1;
            burst_left--;
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // receiver stall pattern: runs of ready/stall with per-phase odds
   int stall_run = 0;
   bit stall_now = 1'b0;
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_now = ($urandom_range(0, 99) < stall_pct);
         stall_run = stall_now ? $urandom_range(1, 120) : $urandom_range(1, 300);
      end
      stall_run--;
      rsp_ready <= !reset && !stall_now;
   end

   // ------------------------------------------------------------------
   // Monitor: predict on each accepted beat, check each result beat
   // ------------------------------------------------------------------
   int quiet_cycles = 0;
   always @(posedge clock) begin
      comp_result_type want;
      if (reset) begin
         shadow_reset();
         quiet_cycles = 0;
      end else begin
         if (csr_valid && csr_ready) shadow_write(csr_index, csr_data);
         if (req_valid && req_ready) begin
            result_q.push_back(compress_sample(req_sample_in));
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               report_mismatch("unexpected result beat", rsp_sample_out, 0);
            end else begin
               want = result_q.pop_front();
               if (rsp_sample_out !== want.smp)
                  report_mismatch("sample_out", rsp_sample_out, want.smp);
               if (rsp_gain_reduction_db !== want.gr)
                  report_mismatch("gain_reduction_db", rsp_gain_reduction_db, want.gr);
               if (rsp_envelope_level_db !== want.lvl)
                  report_mismatch("envelope_level_db", rsp_envelope_level_db, want.lvl);
            end
         end
         // watchdog on cycles with no beat anywhere
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic csr_write(input logic [skbc_pkg::CSR_IDX_W-1:0] idx, input longint v);
      @(negedge clock);
      csr_index <= idx;
      // junk above the register width must be masked off
      csr_data  <= skbc_pkg::CSR_DATA_W'(v) |
                   (($urandom_range(0, 3) == 0) ? ($urandom() << 24) : 32'd0);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic csr_done();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sample_q.size() != 0 || req_valid || result_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // envelope-shaped random material: runs at one loudness, then a new one
   task automatic queue_random_samples(input int count);
      int run, bits, k;
      logic signed [skbc_pkg::SAMPLE_BITS-1:0] v;
      k = 0;
      while (k < count) begin
         run  = $urandom_range(3, 40);
         bits = $urandom_range(0, 23);
         for (int i = 0; i < run && k < count; i++, k++) begin
            case ($urandom_range(0, 9))
               0: v = skbc_pkg::SAMPLE_BITS'($urandom());                 // noise
               1: v = ($urandom_range(0, 1)) ? 24'sh7fffff : 24'sh800000; // rails
               2: v = '0;
               default: begin
                  v = skbc_pkg::SAMPLE_BITS'($urandom_range(0, (1 << bits) - 1) |
                                             (1 << bits));
                  if ($urandom_range(0, 1)) v = -v;
               end
            endcase
            sample_q.push_back(v);
         end
      end
   endtask

   longint cfg [7];

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: unity bypass, silent start, rails and small values
      sample_q = '{24'sd0, 24'sd0, 24'sh7fffff, 24'sh800000, -24'sd1, 24'sd1,
                   24'sh555555, -24'sh2aaaaa, 24'sd0, 24'sh7fffff};
      wait_drained();

      // hard compression, narrow knee, level pinned high, big makeup: saturation
      csr_write(skbc_pkg::REG_RATIO, 5120);
      csr_write(skbc_pkg::REG_KNEE_W, 0);
      csr_write(skbc_pkg::REG_OFFSET, 32767);
      csr_write(skbc_pkg::REG_MAKEUP, 32767);
      csr_write(skbc_pkg::REG_ATTACK, 0);
      csr_write(skbc_pkg::REG_RELEASE, 0);
      csr_write(REG_UNMAPPED, 32'hdead_beef);
      csr_done();
      sample_q = '{24'sh7fffff, 24'sh800000, 24'sd1, 24'sd0, -24'sd77};
      wait_drained();

      // extreme ratio and deep negative makeup: gain vanishes; level pinned low, so no reduction
      csr_write(skbc_pkg::REG_RATIO, 8191);
      csr_write(skbc_pkg::REG_MAKEUP, -32768);
      csr_write(skbc_pkg::REG_KNEE_PT, 0);
      csr_write(skbc_pkg::REG_OFFSET, -32768);
      csr_done();
      sample_q = '{24'sh7fffff, 24'sh800000, 24'sd0, 24'sd12345, -24'sd1};
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         // random settings; the first two phases take fixed low and high settings
         cfg[0] = (p == 0) ? -32768 : (p == 1) ? 32767 : $urandom_range(0, 6000) - 4000;
         cfg[1] = (p == 0) ? 256 : (p == 1) ? 5120 :
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) :
                                                $urandom_range(256, 5120);
         cfg[2] = (p == 0) ? 0 : (p == 1) ? 30720 : $urandom_range(0, 32767);
         cfg[3] = (p == 0) ? 26 : (p == 1) ? 12800 : $urandom_range(0, 16383);
         cfg[4] = (p == 0) ? 0 : (p == 1) ? 24'hffffff :
                  ($urandom_range(0, 1)) ? $urandom_range(0, 24'hffffff) :
                                           24'hffffff - $urandom_range(0, 70000);
         cfg[5] = (p == 0) ? 0 : (p == 1) ? 24'hffffff :
                  ($urandom_range(0, 1)) ? $urandom_range(0, 24'hffffff) :
                                           24'hffffff - $urandom_range(0, 20000);
         cfg[6] = (p == 0) ? -32768 : (p == 1) ? 32767 : $urandom_range(0, 40000) - 10000;
         csr_write(skbc_pkg::REG_MAKEUP,  cfg[0]);
         csr_write(skbc_pkg::REG_RATIO,   cfg[1]);
         csr_write(skbc_pkg::REG_KNEE_PT, cfg[2]);
         csr_write(skbc_pkg::REG_KNEE_W,  cfg[3]);
         csr_write(skbc_pkg::REG_ATTACK,  cfg[4]);
         csr_write(skbc_pkg::REG_RELEASE, cfg[5]);
         csr_write(skbc_pkg::REG_OFFSET,  cfg[6]);
         csr_done();

         // vary pacing; some phases run the driver flat out, some the receiver
         gap_max   = (p % 3 == 0) ? 0 : $urandom_range(1, 200);
         burst_max = $urandom_range(1, 30);
         stall_pct = (p % 4 == 1) ? 0 : $urandom_range(10, 70);

         queue_random_samples(ITEMS_PER_PHASE);
         wait_drained();
      end

      repeat (200) @(posedge clock);
      if (result_q.size() != 0)
         report_mismatch("results never delivered", 0, result_q.size());
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
